@@ hw/rtl/sha256_stream_hasher_defines.svh @@
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
// Assert that an implication holds on every clock edge outside reset.
`define SHS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert that a condition holds in the cycle after another one.
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hw/rtl/shs_pkg.sv @@
// Package with types, constants and functions of the SHA-256 stream hasher.
`default_nettype none
package shs_pkg;
	typedef enum logic [1:0] {
		MODE_DATA = 2'd0,
		MODE_DATA_END = 2'd1,
		MODE_END = 2'd2,
		MODE_END_ALT = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0] word_index;
		logic last_word;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_COMP,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		BSRC_DATA = 2'd0,
		BSRC_PAD80 = 2'd1,
		BSRC_ZERO = 2'd2,
		BSRC_LEN = 2'd3
	} bsrc_t;

	typedef struct packed {
		logic put;
		bsrc_t src;
		logic count_bits;
		logic snap_len;
		logic comp_start;
		logic comp_step;
		logic fold;
		logic emit_load;
		logic emit_adv;
		logic reinit;
	} cmd_t;

	typedef struct packed {
		logic full_next;
		logic [5:0] fill;
		logic round_last;
		logic [2:0] emit_idx;
	} sts_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/shs_datapath.sv @@
// Datapath of the hasher: byte buffer, counters, message schedule and round logic.
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module shs_datapath
	import shs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	input wire logic [7:0] data_byte,
	output sts_t sts,
	output logic [31:0] digest_word
);
	logic [5:0] fill_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0] round_q;
	logic [2:0] emit_q;
	logic [7:0] put_byte;
	logic [2:0] len_sel;
	logic [31:0] w_new, w_cur, t1, t2, s0, s1, b0, b1, ch, mj;

	assign len_sel = fill_q[2:0];

	always_comb begin
		case (cmd.src)
			BSRC_DATA: put_byte = data_byte;
			BSRC_PAD80: put_byte = PAD_BYTE;
			BSRC_ZERO: put_byte = 8'h00;
			BSRC_LEN: put_byte = len_q[63 - 8 * len_sel -: 8];
			default: put_byte = 8'h00;
		endcase
	end

	assign w_cur = w_q[0];
	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_new = s1 + w_q[9] + s0 + w_q[0];
	assign b1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1 = v_q[7] + b1 + ch + ROUND_K[round_q] + w_cur;
	assign b0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
	assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t2 = b0 + mj;

	always_ff @(posedge clk) begin
		if (cmd.snap_len) begin
			len_q <= bits_q;
		end
		if (cmd.put) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], put_byte};
		end else if (cmd.comp_step) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
		if (cmd.comp_start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (cmd.comp_step) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
			round_q <= '0;
			emit_q <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= INIT_HASH[i];
			end
		end else begin
			if (cmd.reinit) begin
				fill_q <= '0;
				bits_q <= '0;
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= INIT_HASH[i];
				end
			end else begin
				if (cmd.put) begin
					fill_q <= fill_q + 6'd1;
				end
				if (cmd.count_bits) begin
					bits_q <= bits_q + 64'd8;
				end
				if (cmd.fold) begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
				end
			end
			if (cmd.comp_start) begin
				round_q <= '0;
			end else if (cmd.comp_step) begin
				round_q <= round_q + 6'd1;
			end
			if (cmd.emit_load) begin
				emit_q <= '0;
			end else if (cmd.emit_adv) begin
				emit_q <= emit_q + 3'd1;
			end
		end
	end

	assign sts.full_next = (fill_q == 6'd63);
	assign sts.fill = fill_q;
	assign sts.round_last = (round_q == 6'd63);
	assign sts.emit_idx = emit_q;
	assign digest_word = hash_q[emit_q];

	`SHS_ASSERT_NEXT(a_fill_wrap, cmd.put && !cmd.reinit && fill_q == 6'd63, fill_q == 6'd0,
		"fill count did not wrap")
	`SHS_ASSERT_NEXT(a_round_adv, cmd.comp_step && !cmd.comp_start && round_q != 6'd63,
		round_q == $past(round_q) + 6'd1, "round counter did not advance")
endmodule
`default_nettype wire

@@ hw/rtl/shs_ctrl.sv @@
// Controller state machine of the hasher.
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module shs_ctrl
	import shs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [1:0] in_mode,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	output cmd_t cmd,
	input wire sts_t sts
);
	state_t state_q, state_nx;
	logic final_q, final_nx;
	logic take;
	logic pad_done_q;
	logic pad_first_q;

	assign take = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_nx = state_q;
		final_nx = final_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_mode == MODE_DATA) begin
						final_nx = 1'b0;
						if (sts.full_next) begin
							state_nx = ST_COMP;
						end
					end else begin
						final_nx = 1'b1;
						state_nx = ST_PAD;
						if (in_mode == MODE_DATA_END && sts.full_next) begin
							state_nx = ST_COMP;
						end
					end
				end
			end
			ST_PAD: begin
				if (sts.fill == 6'd63) begin
					state_nx = ST_COMP;
				end else if (sts.fill == LEN_OFFSET - 6'd1) begin
					state_nx = ST_LEN;
				end
			end
			ST_LEN: begin
				if (sts.fill == 6'd63) begin
					state_nx = ST_COMP;
				end
			end
			ST_COMP: begin
				if (sts.round_last) begin
					state_nx = ST_FOLD;
				end
			end
			ST_FOLD: begin
				state_nx = ST_PAD;
				if (!final_q) begin
					state_nx = ST_IDLE;
				end else if (sts.fill == 6'd0 && pad_done_q) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_stall && sts.emit_idx == 3'd7) begin
					state_nx = ST_IDLE;
					final_nx = 1'b0;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
			pad_done_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			final_q <= final_nx;
			if (state_q == ST_LEN && sts.fill == 6'd63) begin
				pad_done_q <= 1'b1;
			end else if (cmd.reinit) begin
				pad_done_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd = '0;
		cmd.src = BSRC_DATA;
		case (state_q)
			ST_IDLE: begin
				if (take && in_mode != MODE_END && in_mode != MODE_END_ALT) begin
					cmd.put = 1'b1;
					cmd.count_bits = 1'b1;
				end
			end
			ST_PAD: begin
				cmd.put = 1'b1;
				cmd.snap_len = 1'b1;
				cmd.src = pad_first_q ? BSRC_PAD80 : BSRC_ZERO;
			end
			ST_LEN: begin
				cmd.put = 1'b1;
				cmd.src = BSRC_LEN;
			end
			ST_COMP: begin
				cmd.comp_step = 1'b1;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit_adv = !out_stall;
				if (!out_stall && sts.emit_idx == 3'd7) begin
					cmd.reinit = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
		cmd.comp_start = (state_nx == ST_COMP) && (state_q != ST_COMP);
		cmd.emit_load = (state_q == ST_FOLD) && (state_nx == ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_first_q <= 1'b1;
		end else if (state_q == ST_PAD) begin
			pad_first_q <= 1'b0;
		end else if (state_q == ST_EMIT) begin
			pad_first_q <= 1'b1;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);

	`SHS_ASSERT_IMPL(a_no_take_busy, state_q != ST_IDLE, in_stall,
		"input taken while busy")
	`SHS_ASSERT_IMPL(a_out_only_emit, out_valid, final_q && pad_done_q,
		"result shown before padding finished")
	`SHS_ASSERT_NEXT(a_fold_after_comp, state_q == ST_COMP && sts.round_last,
		state_q == ST_FOLD, "compression did not fold")
endmodule
`default_nettype wire

@@ hw/rtl/sha256_stream_hasher.sv @@
// Top level of the SHA-256 stream hasher.
// Usage:
//   Input channel in/in_valid/in_stall carries one transaction per message byte.
//   mode 0 is a byte, mode 1 a byte that ends the message, mode 2 or 3 ends
//   the message without a byte. A byte that fills the 64-byte block makes
//   the shared round unit run 64 rounds (one per cycle) and then a fold
//   step before the next transaction is taken; no byte is taken while a
//   block is compressed. An ending transaction pads the block byte by byte,
//   compresses one or two blocks, then presents eight digest words on
//   out/out_valid/out_stall, word 0 first, one per cycle while out_stall is
//   low. A stalled word holds steady.
//   Input is stalled from the end transaction until the last word is taken.
//   Reset loads the initial hash and clears the byte and bit counters; the
//   block buffer needs no clearing since padding writes every entry.
`default_nettype none
module sha256_stream_hasher
	import shs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output out_item_t out_data
);
	cmd_t cmd;
	sts_t sts;
	logic [31:0] dword;

	shs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_mode(in_data.mode),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd(cmd),
		.sts(sts)
	);

	shs_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.data_byte(in_data.data_byte),
		.sts(sts),
		.digest_word(dword)
	);

	assign out_data.digest_word = dword;
	assign out_data.word_index = sts.emit_idx;
	assign out_data.last_word = (sts.emit_idx == 3'd7);
endmodule
`default_nettype wire

@@ bench/sha256_stream_hasher_checker.sv @@
// Checker for the SHA-256 stream hasher: digest prediction and comparison of every digest word.
module sha256_stream_hasher_checker
	import shs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire out_item_t out_data,
	output int fail_count,
	output int pending,
	output int digests_done
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] chain [8];
	logic [7:0] msg_block [64];
	logic [5:0] fill;
	logic [63:0] msg_bits;
	out_item_t digest_q [$];

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		msg_block[fill] = b;
		fill = fill + 6'd1;
		if (fill == 6'd0)
			compress_block();
	endfunction

	function automatic void restart_message();
		for (int i = 0; i < 8; i++)
			chain[i] = INIT_HASH[i];
		fill = '0;
		msg_bits = '0;
	endfunction

	function automatic void predict_digest(input in_item_t item);
		logic [63:0] len;
		out_item_t word;
		if (item.mode == MODE_DATA || item.mode == MODE_DATA_END) begin
			msg_bits += 64'd8;
			absorb_byte(item.data_byte);
			if (item.mode == MODE_DATA)
				return;
		end
		len = msg_bits;
		absorb_byte(PAD_BYTE);
		while (fill != LEN_OFFSET)
			absorb_byte(8'h00);
		for (int i = 0; i < 8; i++)
			absorb_byte(len[63 - 8*i -: 8]);
		for (int i = 0; i < 8; i++) begin
			word.digest_word = chain[i];
			word.word_index = 3'(i);
			word.last_word = (i == 7);
			digest_q.push_back(word);
		end
		restart_message();
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			restart_message();
			digest_q.delete();
			fail_count <= 0;
			digests_done <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_digest(in_data);
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected digest word", out_data.digest_word, '0);
				end else begin
					want = digest_q.pop_front();
					if (out_data.digest_word !== want.digest_word)
						report_mismatch("digest_word", out_data.digest_word, want.digest_word);
					if (out_data.word_index !== want.word_index)
						report_mismatch("word_index", 32'(out_data.word_index),
							32'(want.word_index));
					if (out_data.last_word !== want.last_word)
						report_mismatch("last_word", 32'(out_data.last_word),
							32'(want.last_word));
					if (want.last_word)
						digests_done++;
				end
			end
		end
		pending = digest_q.size();
	end
endmodule

@@ bench/sha256_stream_hasher_test.sv @@
// Top of the SHA-256 stream hasher bench: clock, reset, message stimulus and verdict.
module sha256_stream_hasher_test
	import shs_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	int fail_count;
	int pending;
	int digests_done;
	int tx_idle_pct;
	int rx_stall_pct;
	int bytes_sent;
	int quiet_cycles;

	sha256_stream_hasher u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	sha256_stream_hasher_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending(pending), .digests_done(digests_done)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("sha256_stream_hasher_test: FAIL");
			$finish;
		end
	end

	task automatic send_item(input mode_t mode, input logic [7:0] b);
		logic taken;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{mode: mode, data_byte: b};
		forever begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
			if (taken)
				break;
		end
		bytes_sent++;
	endtask

	task automatic send_message(input int len, input mode_t ending);
		for (int i = 0; i < len - 1; i++)
			send_item(MODE_DATA, 8'($urandom));
		if (len > 0 && ending == MODE_DATA_END) begin
			send_item(MODE_DATA_END, 8'($urandom));
		end else begin
			if (len > 0)
				send_item(MODE_DATA, 8'($urandom));
			send_item(ending, 8'($urandom));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(12);
		case ($urandom_range(6))
			0: return 55;
			1: return 56;
			2: return 63;
			3: return 64;
			4: return 65;
			5: return 119;
			default: return 120;
		endcase
	endfunction

	function automatic mode_t pick_ending();
		case ($urandom_range(2))
			0: return MODE_DATA_END;
			1: return MODE_END;
			default: return MODE_END_ALT;
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		bytes_sent = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(MODE_END, 8'hff);
		send_item(MODE_END_ALT, 8'h00);
		send_item(MODE_DATA, 8'h61);
		send_item(MODE_DATA, 8'h62);
		send_item(MODE_DATA_END, 8'h63);
		send_item(MODE_DATA, 8'hff);
		send_item(MODE_DATA_END, 8'h00);
		send_item(MODE_DATA, 8'h80);
		send_item(MODE_END, 8'h5a);
		send_item(MODE_DATA_END, 8'hff);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 85 : 0;
			rx_stall_pct = (phase == 0) ? 85 : (phase == 1) ? 9 : 0;
			while (bytes_sent < 10 + 135 * (phase + 1))
				send_message(pick_length(), pick_ending());
			drain();
		end

		repeat (200) @(posedge clk);
		$display("Sent %0d input transactions; %0d digests checked, including empty,",
			bytes_sent, digests_done);
		$display("one- and two-block padding cases under three idle/stall mixes.");
		if (fail_count == 0 && pending == 0)
			$display("sha256_stream_hasher_test: PASS");
		else
			$display("sha256_stream_hasher_test: FAIL");
		$finish;
	end
endmodule
